// ===== hdl/ppmf_pkg.sv =====
package ppmf_pkg;

    localparam int WINDOW_LEN   = 20;
    localparam int NUM_CHANNELS = 3;

    localparam int CODE_W = 12;
    localparam int CH_W   = 2;
    localparam int RANK_W = 5;
    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int ADDR_W = $clog2(NUM_CHANNELS * WINDOW_LEN);

    localparam int QUEUE_DEPTH = NUM_CHANNELS;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [CH_W-1:0]   ch_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam code_t CODE_MAX   = '1;
    localparam code_t CODE_MIN   = '0;
    localparam rank_t RANK_RESET = RANK_W'(9);

    // Window write towards the store
    typedef struct packed {
        logic  en;
        addr_t addr;
        code_t data;
    } ram_wr_t;

    // Channel notice: a window job or the release of a window
    typedef struct packed {
        logic valid;
        ch_t  channel;
    } chan_msg_t;

    function automatic addr_t win_addr(ch_t ch, idx_t idx);
        return ADDR_W'(int'(ch) * WINDOW_LEN + int'(idx));
    endfunction

endpackage

// ===== hdl/ppmf_in_if.sv =====
interface ppmf_in_if;
    import ppmf_pkg::*;

    logic  valid;
    logic  ready;
    ch_t   channel;
    code_t sample;
    logic  frame_end;

    modport source (output valid, channel, sample, frame_end, input ready);
    modport sink   (input valid, channel, sample, frame_end, output ready);
endinterface

// ===== hdl/ppmf_out_if.sv =====
interface ppmf_out_if;
    import ppmf_pkg::*;

    logic  valid;
    logic  ready;
    ch_t   out_channel;
    code_t filtered_vpp;

    modport source (output valid, out_channel, filtered_vpp, input ready);
    modport sink   (input valid, out_channel, filtered_vpp, output ready);
endinterface

// ===== hdl/peak_to_peak_median_filter.sv =====
// Peak-to-peak detector with a rank-select filter over three converter channels.
// samples: valid/ready stream of {channel, sample, frame_end}. Per channel the
//   running max and min of the frame are kept; the frame_end sample closes the
//   frame and its peak-to-peak code goes into that channel's 20-entry window.
// results: valid/ready stream of {out_channel, filtered_vpp}, one per full window,
//   giving the entry of ascending rank select_rank (0 acts as 1, above 20 as 20).
// cfg_wr_en/cfg_wr_data write select_rank; write only while the block is idle.
// Throughput: one sample per cycle. A frame_end for a channel whose full window
//   is still queued or being read out is held off until that read-out ends.
// Per window, the back end pops the queue, reads the 20 entries with one
//   insertion per cycle into a sorted register row, then registers the rank
//   pick as the result.
// The window store has one read port, so its entries are read out one at a time.
// A stalled receiver holds the result register; up to three window jobs queue
//   behind it while samples other than held-off frame ends keep flowing.
// Reset clears running max to 0, running min to 4095, window counts, the job
//   queue and sets select_rank to 9. Window entries need no clearing.
module peak_to_peak_median_filter (
    input  logic                  clk,
    input  logic                  rst_n,
    ppmf_in_if.sink               samples,
    ppmf_out_if.source            results,
    input  logic                  cfg_wr_en,
    input  ppmf_pkg::rank_t       cfg_wr_data
);
    import ppmf_pkg::*;

    rank_t     select_rank_reg;
    ram_wr_t   ram_wr;
    chan_msg_t push;
    chan_msg_t release_win;
    logic      pop;
    ch_t       head;
    logic      not_empty;
    logic      q_full;
    addr_t     rd_addr;
    code_t     rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_rank_reg <= RANK_RESET;
        end
        else if (cfg_wr_en)
        begin
            select_rank_reg <= cfg_wr_data;
        end
    end

    ppmf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .release_win (release_win),
        .q_full      (q_full),
        .ram_wr      (ram_wr),
        .push        (push)
    );

    ppmf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (q_full)
    );

    ppmf_ram #(
        .WIDTH (CODE_W),
        .DEPTH (NUM_CHANNELS * WINDOW_LEN)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ppmf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (not_empty),
        .head        (head),
        .pop         (pop),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .select_rank (select_rank_reg),
        .release_win (release_win),
        .results     (results)
    );
endmodule

// ===== hdl/ppmf_ram.sv =====
module ppmf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== hdl/ppmf_front.sv =====
module ppmf_front (
    input  logic                clk,
    input  logic                rst_n,
    ppmf_in_if.sink             samples,
    input  ppmf_pkg::chan_msg_t release_win,
    input  logic                q_full,
    output ppmf_pkg::ram_wr_t   ram_wr,
    output ppmf_pkg::chan_msg_t push
);
    import ppmf_pkg::*;

    code_t                   max_reg  [NUM_CHANNELS];
    code_t                   min_reg  [NUM_CHANNELS];
    idx_t                    fill_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] busy_reg;
    logic [NUM_CHANNELS-1:0] busy_next;

    ch_t   ch;
    logic  ch_ok;
    logic  fire;
    logic  last_entry;
    code_t new_max;
    code_t new_min;
    code_t vpp;

    assign ch    = samples.channel;
    assign ch_ok = int'(ch) < NUM_CHANNELS;

    // Hold a frame end while that channel's window is still queued or being read out
    assign samples.ready = !(samples.frame_end && ch_ok && busy_reg[ch]);
    assign fire          = samples.valid && samples.ready && ch_ok;

    assign new_max    = (samples.sample > max_reg[ch]) ? samples.sample : max_reg[ch];
    assign new_min    = (samples.sample < min_reg[ch]) ? samples.sample : min_reg[ch];
    assign vpp        = (new_max >= new_min) ? (new_max - new_min) : CODE_MIN;
    assign last_entry = fill_reg[ch] == IDX_W'(WINDOW_LEN - 1);

    assign ram_wr.en   = fire && samples.frame_end;
    assign ram_wr.addr = win_addr(ch, fill_reg[ch]);
    assign ram_wr.data = vpp;

    assign push.valid   = ram_wr.en && last_entry;
    assign push.channel = ch;

    always_comb
    begin
        busy_next = busy_reg;
        if (release_win.valid)
        begin
            busy_next[release_win.channel] = 1'b0;
        end
        if (push.valid)
        begin
            busy_next[ch] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                max_reg[c]  <= CODE_MIN;
                min_reg[c]  <= CODE_MAX;
                fill_reg[c] <= '0;
            end
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (fire)
            begin
                if (samples.frame_end)
                begin
                    max_reg[ch]  <= CODE_MIN;
                    min_reg[ch]  <= CODE_MAX;
                    fill_reg[ch] <= last_entry ? '0 : fill_reg[ch] + 1'b1;
                end
                else
                begin
                    max_reg[ch] <= new_max;
                    min_reg[ch] <= new_min;
                end
            end
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_full)
        else $error("window job pushed into a full queue");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr.en |-> !busy_reg[ch])
        else $error("window written while being read out");

    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        release_win.valid |-> busy_reg[release_win.channel])
        else $error("release of a window that was not pending");
endmodule

// ===== hdl/ppmf_queue.sv =====
module ppmf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  ppmf_pkg::chan_msg_t push,
    input  logic                pop,
    output ppmf_pkg::ch_t       head,
    output logic                not_empty,
    output logic                full
);
    import ppmf_pkg::*;

    ch_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = int'(count_reg) == QUEUE_DEPTH;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.channel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            unique case ({push.valid, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule

// ===== hdl/ppmf_back.sv =====
module ppmf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  ppmf_pkg::ch_t       head,
    output logic                pop,
    output ppmf_pkg::addr_t     rd_addr,
    input  ppmf_pkg::code_t     rd_data,
    input  ppmf_pkg::rank_t     select_rank,
    output ppmf_pkg::chan_msg_t release_win,
    ppmf_out_if.source          results
);
    import ppmf_pkg::*;

    typedef enum logic [1:0] {IDLE, LOAD, PICK, HOLD} state_t;

    state_t                state_reg;
    ch_t                   ch_reg;
    logic [CNT_W-1:0]      rd_cnt_reg;
    logic                  pend_reg;
    ch_t                   out_ch_reg;
    code_t                 out_vpp_reg;

    code_t                 sorted_reg  [WINDOW_LEN];
    code_t                 sorted_next [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] vld_reg;
    logic [WINDOW_LEN-1:0] vld_next;
    logic [WINDOW_LEN-1:0] gt;

    logic issue;
    idx_t pick_idx;

    assign issue   = (state_reg == LOAD) && (int'(rd_cnt_reg) != WINDOW_LEN);
    assign rd_addr = win_addr(ch_reg, rd_cnt_reg[IDX_W-1:0]);
    assign pop     = (state_reg == IDLE) && not_empty;

    // Free the window as the read of its last entry is issued
    assign release_win.valid   = issue && (int'(rd_cnt_reg) == WINDOW_LEN - 1);
    assign release_win.channel = ch_reg;

    assign results.valid        = state_reg == HOLD;
    assign results.out_channel  = out_ch_reg;
    assign results.filtered_vpp = out_vpp_reg;

    always_comb
    begin
        if (select_rank == '0)
        begin
            pick_idx = '0;
        end
        else if (int'(select_rank) > WINDOW_LEN)
        begin
            pick_idx = IDX_W'(WINDOW_LEN - 1);
        end
        else
        begin
            pick_idx = IDX_W'(int'(select_rank) - 1);
        end
    end

    // Sorted insertion: empty slots count as larger than anything
    always_comb
    begin
        for (int k = 0; k < WINDOW_LEN; k++)
        begin
            gt[k] = !vld_reg[k] || (sorted_reg[k] > rd_data);
        end
        sorted_next[0] = gt[0] ? rd_data : sorted_reg[0];
        vld_next[0]    = gt[0] ? 1'b1 : vld_reg[0];
        for (int k = 1; k < WINDOW_LEN; k++)
        begin
            priority if (gt[k] && gt[k-1])
            begin
                sorted_next[k] = sorted_reg[k-1];
                vld_next[k]    = vld_reg[k-1];
            end
            else if (gt[k])
            begin
                sorted_next[k] = rd_data;
                vld_next[k]    = 1'b1;
            end
            else
            begin
                sorted_next[k] = sorted_reg[k];
                vld_next[k]    = vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            sorted_reg <= sorted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pop)
        begin
            vld_reg <= '0;
        end
        else if (pend_reg)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= IDLE;
            ch_reg      <= '0;
            rd_cnt_reg  <= '0;
            pend_reg    <= 1'b0;
            out_ch_reg  <= '0;
            out_vpp_reg <= '0;
        end
        else
        begin
            pend_reg <= issue;
            unique case (state_reg)
                IDLE:
                begin
                    if (not_empty)
                    begin
                        ch_reg     <= head;
                        rd_cnt_reg <= '0;
                        state_reg  <= LOAD;
                    end
                end
                LOAD:
                begin
                    if (issue)
                    begin
                        rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    end
                    else if (pend_reg)
                    begin
                        state_reg <= PICK;
                    end
                end
                PICK:
                begin
                    out_ch_reg  <= ch_reg;
                    out_vpp_reg <= sorted_reg[pick_idx];
                    state_reg   <= HOLD;
                end
                HOLD:
                begin
                    if (results.ready)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    a_window_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PICK) |-> (&vld_reg))
        else $error("rank picked from an incomplete window");

    a_release_once: assert property (@(posedge clk) disable iff (!rst_n)
        release_win.valid |=> !release_win.valid && (state_reg == LOAD))
        else $error("window released twice or outside the load phase");
endmodule
